[rtl/sft_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types and constants for the sorted key/count table.
// ----------------------------------------------------------------------------
package sft_pkg;

	localparam int CAPACITY   = 64;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 16;
	localparam int POS_BITS   = 6;
	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int USED_BITS  = $clog2(CAPACITY + 1);
	localparam int CMP_BITS   = (POS_BITS > USED_BITS) ? POS_BITS : USED_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] cnt;
	} ent_t;

	typedef struct packed {
		logic                 cmp;
		logic                 inc;
		logic                 ins;
		logic                 rem;
		logic [KEY_BITS-1:0]  key;
		logic [USED_BITS-1:0] used;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/sft_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sft_cell
// One table slot: holds a key and count, compares against the transaction
// key and shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sft_cell
	import sft_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IDX_BITS-1:0] idx,
	input  wire ctl_t                ctl,
	input  wire ent_t                left_ent,
	input  wire logic                left_lt,
	input  wire ent_t                right_ent,
	output ent_t                     ent,
	output logic                     lt,
	output logic                     eq
);

	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  lt_q;
	logic                  eq_q;
	logic                  valid;

	assign valid = {1'b0, idx} < ctl.used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= valid && (key_q < ctl.key);
			eq_q <= valid && (key_q == ctl.key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.inc && eq_q) begin
			if (cnt_q != COUNT_MAX) begin
				cnt_q <= cnt_q + COUNT_ONE;
			end
		end else if (ctl.ins && !lt_q) begin
			if (left_lt) begin
				key_q <= ctl.key;
				cnt_q <= COUNT_ONE;
			end else begin
				key_q <= left_ent.key;
				cnt_q <= left_ent.cnt;
			end
		end else if (ctl.rem && !lt_q) begin
			key_q <= right_ent.key;
			cnt_q <= right_ent.cnt;
		end
	end

	assign ent.key = key_q;
	assign ent.cnt = cnt_q;
	assign lt      = lt_q;
	assign eq      = eq_q;

endmodule
`default_nettype wire

[rtl/sorted_frequency_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_frequency_table
// Sorted key/count table built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Every
// transaction produces one result: the cell chain compares all entries in
// S_CMP and shifts or counts in S_UPD, and a new transaction may be taken
// in S_UPD, before the result of the last one is shown. The result sits on
// the output ports with done high for one cycle and stays there until the
// next transaction's update; the receiver cannot stall it. Table contents
// outside the entries in use are never shown.
// ----------------------------------------------------------------------------
module sorted_frequency_table
	import sft_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            kind,
	input  wire logic [KEY_BITS-1:0]   key,
	input  wire logic [POS_BITS-1:0]   position,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [KEY_BITS-1:0]        entry_key,
	output logic [COUNT_BITS-1:0]      entry_count,
	output logic [USED_BITS-1:0]       entries_used
);

	state_t                state_q, state_d;
	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [POS_BITS-1:0]   pos_q;
	logic [USED_BITS-1:0]  used_q, used_d;
	logic [IDX_BITS-1:0]   rd_idx_q;
	logic                  accept;
	logic                  done_q;
	status_t               status_q, status_d;
	logic [KEY_BITS-1:0]   rkey_q, rkey_d;
	logic [COUNT_BITS-1:0] rcnt_q, rcnt_d;

	ctl_t                  ctl;
	ent_t                  ent [CAPACITY];
	logic                  lt  [CAPACITY];
	logic                  eq  [CAPACITY];

	logic                  any_eq;
	logic [COUNT_BITS-1:0] hit_cnt;
	logic [COUNT_BITS-1:0] hit_cnt_next;
	logic                  full;
	logic                  empty;
	logic [CMP_BITS-1:0]   pos_ext;
	logic [CMP_BITS-1:0]   used_ext;
	logic [CMP_BITS-1:0]   sel_ext;

	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;
	assign full   = (used_q == USED_BITS'(CAPACITY));
	assign empty  = (used_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			done_q  <= (state_q == S_UPD);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(kind);
			key_q <= key;
			pos_q <= position;
		end
		if (state_q == S_CMP) begin
			rd_idx_q <= sel_ext[IDX_BITS-1:0];
		end
		if (state_q == S_UPD) begin
			status_q <= status_d;
			rkey_q   <= rkey_d;
			rcnt_q   <= rcnt_d;
		end
	end

	// clamp read position to the last entry in use
	assign pos_ext  = CMP_BITS'(pos_q);
	assign used_ext = CMP_BITS'(used_q);
	assign sel_ext  = (pos_ext < used_ext) ? pos_ext : (used_ext - CMP_BITS'(1));

	always_comb begin
		any_eq  = 1'b0;
		hit_cnt = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			any_eq  = any_eq | eq[i];
			hit_cnt = hit_cnt | (eq[i] ? ent[i].cnt : '0);
		end
	end

	assign hit_cnt_next = (hit_cnt == COUNT_MAX) ? hit_cnt : (hit_cnt + COUNT_ONE);

	always_comb begin
		state_d  = state_q;
		used_d   = used_q;
		ctl      = '0;
		ctl.key  = key_q;
		ctl.used = used_q;
		status_d = ST_OK;
		rkey_d   = '0;
		rcnt_d   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctl.cmp = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				state_d = accept ? S_CMP : S_IDLE;
				case (op_q)
					OP_INSERT: begin
						rkey_d = key_q;
						if (any_eq) begin
							ctl.inc = 1'b1;
							rcnt_d  = hit_cnt_next;
						end else if (full) begin
							status_d = ST_FULL;
						end else begin
							ctl.ins = 1'b1;
							used_d  = used_q + USED_BITS'(1);
							rcnt_d  = COUNT_ONE;
						end
					end
					OP_REMOVE: begin
						rkey_d = key_q;
						if (empty) begin
							status_d = ST_EMPTY;
						end else if (!any_eq) begin
							status_d = ST_NOT_FOUND;
						end else begin
							ctl.rem = 1'b1;
							used_d  = used_q - USED_BITS'(1);
						end
					end
					OP_READ: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else begin
							rkey_d = ent[rd_idx_q].key;
							rcnt_d = ent[rd_idx_q].cnt;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		ent_t left_ent;
		logic left_lt;
		ent_t right_ent;

		if (g == 0) begin : g_first
			assign left_ent = ent[g];
			assign left_lt  = 1'b1;
		end else begin : g_mid_l
			assign left_ent = ent[g-1];
			assign left_lt  = lt[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_ent = ent[g];
		end else begin : g_mid_r
			assign right_ent = ent[g+1];
		end

		sft_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_BITS'(g)),
			.ctl       (ctl),
			.left_ent  (left_ent),
			.left_lt   (left_lt),
			.right_ent (right_ent),
			.ent       (ent[g]),
			.lt        (lt[g]),
			.eq        (eq[g])
		);
	end

	assign done         = done_q;
	assign status       = status_q;
	assign entry_key    = rkey_q;
	assign entry_count  = rcnt_q;
	assign entries_used = used_q;

endmodule
`default_nettype wire
